// ===== hw/rtl/nt3_pkg.sv =====
// ----------------------------------------------------------------------------
// nt3_pkg
// Shared types and constants for the nearest-three-to-target sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package nt3_pkg;

    localparam int          CFG_W       = 12;
    localparam int          APB_DW      = 32;
    localparam int          APB_AW      = 3;
    localparam int          OUT_FIELDS  = 3;
    localparam logic [11:0] EMPTY_RESET = 12'hFFF;

    // register index, taken from paddr[2]
    localparam logic        REG_EMPTY_DIST = 1'b0;

    typedef struct packed {
        logic load;
        logic clear;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== hw/rtl/nt3_cell.sv =====
// ----------------------------------------------------------------------------
// nt3_cell
// One sorter slot: holds a distance and a value, inserts or shifts from left.
// ----------------------------------------------------------------------------
`default_nettype none

module nt3_cell #(
    parameter int ANGLE_BITS = 12
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire nt3_pkg::t_cell_ctrl i_ctrl,
    input  wire  [ANGLE_BITS-1:0]    i_empty,
    input  wire  [ANGLE_BITS-1:0]    i_dist,
    input  wire  [ANGLE_BITS-1:0]    i_value,
    input  wire  [ANGLE_BITS-1:0]    i_left_d,
    input  wire  [ANGLE_BITS-1:0]    i_left_v,
    input  wire                      i_left_ins,
    output logic [ANGLE_BITS-1:0]    o_d,
    output logic [ANGLE_BITS-1:0]    o_v,
    output logic                     o_ins,
    output logic [ANGLE_BITS-1:0]    o_next_v
);
    import nt3_pkg::*;

    localparam logic [ANGLE_BITS-1:0] RST_D = ANGLE_BITS'(EMPTY_RESET);

    logic [ANGLE_BITS-1:0] r_d;
    logic [ANGLE_BITS-1:0] r_v;
    logic [ANGLE_BITS-1:0] n_d;
    logic [ANGLE_BITS-1:0] n_v;

    always_comb begin
        o_d   = i_ctrl.clear ? i_empty : r_d;
        o_v   = i_ctrl.clear ? '0 : r_v;
        o_ins = (i_dist < o_d);
        if (i_left_ins) begin
            n_d = i_left_d;
            n_v = i_left_v;
        end else if (o_ins) begin
            n_d = i_dist;
            n_v = i_value;
        end else begin
            n_d = o_d;
            n_v = o_v;
        end
        o_next_v = n_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= RST_D;
            r_v <= '0;
        end else if (i_ctrl.load) begin
            r_d <= n_d;
            r_v <= n_v;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/nt3_obuf.sv =====
// ----------------------------------------------------------------------------
// nt3_obuf
// Two-entry result buffer between the slot chain and the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module nt3_obuf #(
    parameter int W = 40
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    output logic         o_ready,
    input  wire  [W-1:0] i_data,
    output logic         o_valid,
    input  wire          i_ready,
    output logic [W-1:0] o_data
);
    logic [1:0]   r_cnt;
    logic [W-1:0] r_head;
    logic [W-1:0] r_tail;
    logic         push;
    logic         pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_head;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && r_cnt == 2'd2) begin
            r_head <= r_tail;
        end
        if (push) begin
            if (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop)) begin
                r_head <= i_data;
            end else begin
                r_tail <= i_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/nearest_three_to_target_top.sv =====
// ----------------------------------------------------------------------------
// nearest_three_to_target_top
// Streaming sorter keeping the values closest to a target angle.
// ----------------------------------------------------------------------------
//  channel   dir  contents
//  s_axis    in   tdata: angle, target_angle; tuser: clear
//  m_axis    out  tdata: nearest_first, nearest_second, nearest_third
//  apb       in   reg 0 (addr 0): empty_distance, 12 bits
//
//  One request per cycle while the output buffer has room; each slot
//  cell compares and updates on accept, and the buffer registers the result.
//  Two-entry output buffer: input stalls only when both entries are full.
//  Synchronous active-low reset loads every slot with the empty sentinel.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_three_to_target_top #(
    parameter int SLOTS      = 3,
    parameter int ANGLE_BITS = 12,
    parameter int IN_W       = ((2 * ANGLE_BITS + 7) / 8) * 8,
    parameter int OUT_W      = ((3 * ANGLE_BITS + 7) / 8) * 8
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // angle (low), target_angle
    input  wire  [IN_W-1:0]            s_axis_tdata,
    // clear
    input  wire                        s_axis_tuser,
    input  wire                        s_axis_tvalid,
    output logic                       s_axis_tready,
    // nearest_first (low), nearest_second, nearest_third
    output logic [OUT_W-1:0]           m_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire                        m_axis_tready,
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire  [nt3_pkg::APB_AW-1:0] paddr,
    input  wire  [nt3_pkg::APB_DW-1:0] pwdata,
    output logic [nt3_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import nt3_pkg::*;

    localparam int AB = ANGLE_BITS;

    logic [CFG_W-1:0]       r_empty;
    logic [AB+CFG_W-1:0]    empty_ext;
    logic [AB-1:0]          empty_d;
    logic signed [AB-1:0]   angle;
    logic signed [AB-1:0]   target;
    logic signed [AB:0]     diff;
    logic [AB:0]            mag;
    logic [AB-1:0]          new_dist;
    logic                   accept;
    t_cell_ctrl             ctrl;
    logic [AB-1:0]          link_d   [SLOTS+1];
    logic [AB-1:0]          link_v   [SLOTS+1];
    logic                   link_ins [SLOTS+1];
    logic [AB-1:0]          next_v   [SLOTS];
    logic [AB-1:0]          res      [OUT_FIELDS];
    logic [3*AB-1:0]        res_pack;

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty <= EMPTY_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_EMPTY_DIST) begin
            r_empty <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata    = (paddr[2] == REG_EMPTY_DIST) ? APB_DW'(r_empty) : '0;
    assign empty_ext = {{AB{1'b0}}, r_empty};
    assign empty_d   = empty_ext[AB-1:0];

    // distance, saturated to AB bits
    assign angle    = s_axis_tdata[AB-1:0];
    assign target   = s_axis_tdata[2*AB-1:AB];
    assign diff     = {angle[AB-1], angle} - {target[AB-1], target};
    assign mag      = diff[AB] ? (~diff + 1'b1) : diff;
    assign new_dist = mag[AB] ? '1 : mag[AB-1:0];

    assign accept     = s_axis_tvalid && s_axis_tready;
    assign ctrl.load  = accept;
    assign ctrl.clear = s_axis_tuser;

    assign link_d[0]   = '0;
    assign link_v[0]   = '0;
    assign link_ins[0] = 1'b0;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        nt3_cell #(
            .ANGLE_BITS (AB)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_empty    (empty_d),
            .i_dist     (new_dist),
            .i_value    (angle),
            .i_left_d   (link_d[i]),
            .i_left_v   (link_v[i]),
            .i_left_ins (link_ins[i]),
            .o_d        (link_d[i+1]),
            .o_v        (link_v[i+1]),
            .o_ins      (link_ins[i+1]),
            .o_next_v   (next_v[i])
        );
    end

    for (genvar k = 0; k < OUT_FIELDS; k++) begin : g_res
        if (k < SLOTS) begin : g_slot
            assign res[k] = next_v[k];
        end else begin : g_zero
            assign res[k] = '0;
        end
        assign res_pack[k*AB +: AB] = res[k];
    end

    nt3_obuf #(
        .W (OUT_W)
    ) u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (OUT_W'(res_pack)),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/nt3_chk.sv =====
// ----------------------------------------------------------------------------
// nt3_chk
// Port-level checks for the nearest-three-to-target sorter.
// ----------------------------------------------------------------------------
`default_nettype none

module nt3_chk #(
    parameter int ANGLE_BITS = 12,
    parameter int IN_W       = 24,
    parameter int OUT_W      = 40
) (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire [IN_W-1:0]  s_axis_tdata,
    input wire             s_axis_tuser,
    input wire             s_axis_tvalid,
    input wire             s_axis_tready,
    input wire [OUT_W-1:0] m_axis_tdata,
    input wire             m_axis_tvalid,
    input wire             m_axis_tready
);
    localparam int AB = ANGLE_BITS;

    a_idle_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no pending result");

    a_request_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> m_axis_tvalid)
        else $error("accepted request produced no result");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid
        |=> m_axis_tdata[3*AB-1:AB] == '0)
        else $error("clear left stale values behind the first slot");

endmodule

bind nearest_three_to_target_top nt3_chk #(
    .ANGLE_BITS (ANGLE_BITS),
    .IN_W       (IN_W),
    .OUT_W      (OUT_W)
) u_nt3_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire

// ===== tb/sv/tb_nearest_three_to_target_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_three_to_target_top
// Self-checking bench for the nearest-three-to-target streaming sorter.
// ----------------------------------------------------------------------------
// A local model keeps three distance/value slots and the empty sentinel.
// It predicts the slot values for every request that the block takes in.
// Each output beat is checked against the oldest prediction.
// The bench first runs directed cases: reset state, field extremes, ties,
// clear together with an item, and sentinel values including an ignored
// register write. It then runs runs of items around a random target.
// Both stream sides idle at random, with one stretch that has no idling.
// The APB register is written only while no results are pending.
// ----------------------------------------------------------------------------

module tb_nearest_three_to_target_top;

    import nt3_pkg::*;

    localparam int          SLOTS       = 3;
    localparam int          AW          = 12;
    localparam int          CLK_HALF    = 6;
    localparam int unsigned CYCLE_LIMIT = 400000;
    // index 1 does not exist; writes there must be ignored
    localparam logic        REG_UNUSED  = 1'b1;

    typedef struct packed {
        logic [AW-1:0] third;
        logic [AW-1:0] second;
        logic [AW-1:0] first;
    } nearest_t;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic [23:0]         s_axis_tdata  = '0;
    logic                s_axis_tuser  = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [39:0]         m_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [APB_AW-1:0]   paddr         = '0;
    logic [APB_DW-1:0]   pwdata        = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    logic [CFG_W-1:0]    empty_dist;
    logic [AW-1:0]       near_dist [SLOTS];
    logic [AW-1:0]       near_val  [SLOTS];
    nearest_t            pending_nearest[$];
    int                  mismatches    = 0;
    bit                  gaps_on       = 1'b1;
    int unsigned         cycles        = 0;

    nearest_three_to_target_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // sink side
    always @(posedge i_clk) begin
        m_axis_tready <= !gaps_on || ($urandom_range(99) >= 29);
    end

    function automatic void empty_slots();
        for (int i = 0; i < SLOTS; i++) begin
            near_dist[i] = empty_dist;
            near_val[i]  = '0;
        end
    endfunction

    function automatic nearest_t insert_candidate(logic [AW-1:0] ang, logic [AW-1:0] tgt,
                                                  logic clr);
        int            diff;
        int            pos;
        logic [AW-1:0] cand_dist;
        nearest_t      res;
        diff = int'($signed(ang)) - int'($signed(tgt));
        if (diff < 0)
            diff = -diff;
        if (diff > (1 << AW) - 1)
            diff = (1 << AW) - 1;
        cand_dist = diff[AW-1:0];
        if (clr)
            empty_slots();
        pos = SLOTS;
        for (int i = 0; i < SLOTS; i++) begin
            if (cand_dist < near_dist[i]) begin
                pos = i;
                break;
            end
        end
        if (pos < SLOTS) begin
            for (int k = SLOTS - 1; k > pos; k--) begin
                near_dist[k] = near_dist[k-1];
                near_val[k]  = near_val[k-1];
            end
            near_dist[pos] = cand_dist;
            near_val[pos]  = ang;
        end
        res.first  = near_val[0];
        res.second = near_val[1];
        res.third  = near_val[2];
        return res;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        nearest_t want;
        nearest_t got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[35:0];
            if (pending_nearest.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_nearest.pop_front();
                if (got.first !== want.first) begin
                    $error("nearest_first: expected %0d, got %0d",
                           $signed(want.first), $signed(got.first));
                    mismatches++;
                end
                if (got.second !== want.second) begin
                    $error("nearest_second: expected %0d, got %0d",
                           $signed(want.second), $signed(got.second));
                    mismatches++;
                end
                if (got.third !== want.third) begin
                    $error("nearest_third: expected %0d, got %0d",
                           $signed(want.third), $signed(got.third));
                    mismatches++;
                end
            end
        end
    end

    task automatic send_request(input logic [AW-1:0] ang, input logic [AW-1:0] tgt,
                                input logic clr);
        while (gaps_on && $urandom_range(99) < 29) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tgt, ang};
        s_axis_tuser  <= clr;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        pending_nearest.push_back(insert_candidate(ang, tgt, clr));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_nearest.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // write one register, then read back empty_distance
    task automatic cfg_write(input logic reg_idx, input logic [CFG_W-1:0] val);
        logic [APB_DW-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {20'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (reg_idx == REG_EMPTY_DIST)
            empty_dist = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_EMPTY_DIST, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (rd !== APB_DW'(empty_dist)) begin
            $error("empty_distance: expected %0d, got %0d", empty_dist, rd);
            mismatches++;
        end
    endtask

    task automatic set_sentinel(input logic [CFG_W-1:0] val);
        drain_results();
        cfg_write(REG_EMPTY_DIST, val);
    endtask

    task automatic run_random(input int count);
        logic [AW-1:0] tgt;
        logic [AW-1:0] ang;
        logic          clr;
        int            run_left;
        run_left = 0;
        tgt      = '0;
        for (int n = 0; n < count; n++) begin
            clr = 1'b0;
            if (run_left == 0) begin
                tgt      = AW'($urandom);
                run_left = $urandom_range(20, 3);
                clr      = ($urandom_range(3) != 0);
            end
            run_left--;
            case ($urandom_range(7))
                0, 1:    ang = AW'($urandom);
                2:       ang = tgt;
                default: ang = tgt + AW'($urandom_range(40)) - AW'(20);
            endcase
            // noise: stray clears and target jumps inside a run
            if ($urandom_range(19) == 0)
                clr = 1'b1;
            if ($urandom_range(29) == 0)
                tgt = AW'($urandom);
            send_request(ang, tgt, clr);
        end
    endtask

    task automatic test_reset_state();
        cfg_write(REG_EMPTY_DIST, EMPTY_RESET);
        // largest distance equals the sentinel: not inserted
        send_request(12'h800, 12'h7FF, 1'b0);
        send_request(12'd100, 12'd90, 1'b0);
    endtask

    task automatic test_extremes();
        send_request(12'h7FF, 12'h800, 1'b1);
        send_request(12'h800, 12'h800, 1'b0);
        send_request(12'h7FF, 12'h7FF, 1'b0);
        send_request(12'h000, 12'hFFF, 1'b0);
        send_request(12'hFFF, 12'h000, 1'b0);
    endtask

    task automatic test_ties_and_clear();
        send_request(12'd5, 12'd0, 1'b1);
        send_request(-12'sd5, 12'd0, 1'b0);
        send_request(12'd3, 12'd0, 1'b0);
        send_request(12'd5, 12'd0, 1'b0);
        send_request(-12'sd3, 12'd0, 1'b0);
        send_request(12'd0, 12'd0, 1'b0);
        send_request(12'd7, 12'd7, 1'b1);
    endtask

    task automatic test_sentinel_register();
        set_sentinel(12'd0);
        send_request(12'd10, 12'd10, 1'b1);
        set_sentinel(12'd1);
        send_request(12'd10, 12'd10, 1'b1);
        send_request(12'd11, 12'd10, 1'b0);
        drain_results();
        cfg_write(REG_UNUSED, 12'h123);
        send_request(12'h000, 12'h000, 1'b1);
        send_request(12'h001, 12'h000, 1'b0);
        set_sentinel(EMPTY_RESET);
    endtask

    task automatic test_random_traffic();
        run_random(400);
        set_sentinel(12'd0);
        run_random(100);
        set_sentinel(AW'($urandom_range(4094, 1)));
        run_random(300);
    endtask

    task automatic test_drain_pause();
        set_sentinel(EMPTY_RESET);
        for (int i = 0; i < 4; i++) begin
            run_random(50);
            drain_results();
        end
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        run_random(400);
        drain_results();
        gaps_on = 1'b1;
        set_sentinel(12'd2048);
        run_random(250);
    endtask

    initial begin
        empty_dist = EMPTY_RESET;
        empty_slots();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_extremes();
        test_ties_and_clear();
        test_sentinel_register();
        test_random_traffic();
        test_drain_pause();
        test_back_to_back();

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/nt3_pkg.sv
hw/rtl/nt3_cell.sv
hw/rtl/nt3_obuf.sv
hw/rtl/nearest_three_to_target_top.sv
hw/rtl/nt3_chk.sv
tb/sv/tb_nearest_three_to_target_top.sv
